// ----- rtl/bps_pkg.sv -----
`default_nettype none
package bps_pkg;

	localparam int MAX_NOTES = 64;
	localparam int NOTE_AW   = $clog2(MAX_NOTES);
	localparam int POS_W     = $clog2(MAX_NOTES + 1);

	localparam int LEN_W  = 7;
	localparam int FREQ_W = 16;
	localparam int MS_W   = 16;
	localparam int TLEN_W = 8;
	localparam int MODE_W = 3;
	localparam int SLOT_W = 6;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 7;

	localparam logic [CFG_IW-1:0] CFG_MELODY_PRESENT = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_MELODY_LENGTH  = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_MELODY_LOOP    = 2'd2;

	localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_READY     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ERROR     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REVERSING = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CUSTOM    = 3'd4;

	localparam logic [MS_W-1:0] READY_PERIOD_MS     = 16'd1000;
	localparam logic [MS_W-1:0] ERROR_PERIOD_MS     = 16'd300;
	localparam logic [MS_W-1:0] REVERSING_PERIOD_MS = 16'd500;

	localparam logic [FREQ_W-1:0] READY_FREQ_HZ     = 16'd1000;
	localparam logic [FREQ_W-1:0] ERROR_FREQ_HZ     = 16'd400;
	localparam logic [FREQ_W-1:0] REVERSING_FREQ_HZ = 16'd600;
	localparam logic [TLEN_W-1:0] BEEP_LEN_MS       = 8'd100;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_TIMED   = 2'd1,
		CMD_CONT    = 2'd2,
		CMD_SILENCE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [FREQ_W-1:0] pitch;
		logic [MS_W-1:0]   wait_ms;
	} note_t;

	typedef struct packed {
		logic             present;
		logic [LEN_W-1:0] length;
		logic             loop_en;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] prev_mode;
		logic [MS_W-1:0]   elapsed;
		logic              phase;
		logic [POS_W-1:0]  pos;
	} seq_state_t;

	typedef struct packed {
		logic              valid;
		cmd_t              command;
		logic [FREQ_W-1:0] freq;
		logic [TLEN_W-1:0] len;
	} step_res_t;

endpackage
`default_nettype wire

// ----- rtl/bps_note_mem.sv -----
`default_nettype none
module bps_note_mem (
	input  wire                              clk,
	input  wire                              wr_en,
	input  wire  [bps_pkg::NOTE_AW-1:0]      wr_addr,
	input  wire  bps_pkg::note_t             wr_data,
	input  wire  [bps_pkg::NOTE_AW-1:0]      rd_addr,
	output bps_pkg::note_t                   rd_data
);

	bps_pkg::note_t mem [bps_pkg::MAX_NOTES];
	bps_pkg::note_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// forward a write to the same slot so the next item sees new data
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

// ----- rtl/bps_step.sv -----
`default_nettype none
module bps_step (
	input  wire                              kind,
	input  wire  [bps_pkg::MODE_W-1:0]       mode,
	input  wire  bps_pkg::cfg_t              cfg,
	input  wire  bps_pkg::seq_state_t        cur,
	input  wire  bps_pkg::note_t             rd_note,
	input  wire  bps_pkg::note_t             first_note,
	output bps_pkg::seq_state_t              nxt,
	output bps_pkg::step_res_t               res
);

	logic                          changed;
	logic [bps_pkg::MS_W-1:0]      el0;
	logic [bps_pkg::POS_W-1:0]     pos0;
	logic [bps_pkg::POS_W-1:0]     limit;
	bps_pkg::note_t                note;
	bps_pkg::cmd_t                 cmd;
	logic [bps_pkg::FREQ_W-1:0]    freq;
	logic [bps_pkg::TLEN_W-1:0]    len;

	always_comb begin
		nxt     = cur;
		res     = '0;
		changed = (mode != cur.prev_mode);
		el0     = cur.elapsed;
		pos0    = cur.pos;
		cmd     = bps_pkg::CMD_NONE;
		freq    = '0;
		len     = '0;
		if ({1'b0, cfg.length} > (bps_pkg::LEN_W+1)'(bps_pkg::MAX_NOTES)) begin
			limit = bps_pkg::POS_W'(bps_pkg::MAX_NOTES);
		end else begin
			limit = bps_pkg::POS_W'(cfg.length);
		end
		note = (pos0 == '0) ? first_note : rd_note;

		if (kind) begin
			nxt.elapsed = '0;
			nxt.pos     = '0;
		end else begin
			nxt.prev_mode = mode;
			if (changed) begin
				el0  = '0;
				pos0 = '0;
				note = first_note;
			end else if (cur.elapsed != '1) begin
				el0 = cur.elapsed + 1'b1;
			end
			nxt.elapsed = el0;
			nxt.pos     = pos0;

			case (mode)
				bps_pkg::MODE_READY: begin
					if (el0 >= bps_pkg::READY_PERIOD_MS) begin
						nxt.elapsed = '0;
						cmd  = bps_pkg::CMD_TIMED;
						freq = bps_pkg::READY_FREQ_HZ;
						len  = bps_pkg::BEEP_LEN_MS;
					end
				end
				bps_pkg::MODE_ERROR: begin
					if (el0 >= bps_pkg::ERROR_PERIOD_MS) begin
						nxt.elapsed = '0;
						nxt.phase   = ~cur.phase;
						if (!cur.phase) begin
							cmd  = bps_pkg::CMD_CONT;
							freq = bps_pkg::ERROR_FREQ_HZ;
						end else begin
							cmd = bps_pkg::CMD_SILENCE;
						end
					end
				end
				bps_pkg::MODE_REVERSING: begin
					if (el0 >= bps_pkg::REVERSING_PERIOD_MS) begin
						nxt.elapsed = '0;
						cmd  = bps_pkg::CMD_TIMED;
						freq = bps_pkg::REVERSING_FREQ_HZ;
						len  = bps_pkg::BEEP_LEN_MS;
					end
				end
				bps_pkg::MODE_CUSTOM: begin
					if (cfg.present) begin
						if (pos0 < limit) begin
							if (el0 >= note.wait_ms) begin
								nxt.elapsed = '0;
								nxt.pos     = pos0 + 1'b1;
								if (note.pitch != '0) begin
									cmd  = bps_pkg::CMD_CONT;
									freq = note.pitch;
								end else begin
									cmd = bps_pkg::CMD_SILENCE;
								end
							end
						end else begin
							if (cfg.loop_en) begin
								nxt.pos = '0;
							end
							cmd = bps_pkg::CMD_SILENCE;
						end
					end
				end
				default: begin
					cmd = bps_pkg::CMD_SILENCE;
				end
			endcase

			if (changed && (cmd == bps_pkg::CMD_NONE || cmd == bps_pkg::CMD_SILENCE)) begin
				res.valid   = 1'b1;
				res.command = bps_pkg::CMD_SILENCE;
			end else if (cmd != bps_pkg::CMD_NONE) begin
				res.valid   = 1'b1;
				res.command = cmd;
				res.freq    = freq;
				res.len     = len;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/buzzer_pattern_sequencer_core.sv -----
// Buzzer pattern sequencer.
// Input channel (in_valid/in_stall) carries one item per transfer: kind 0 is
// a one-millisecond tick with the requested mode, kind 1 writes one melody
// note (pitch and wait) into the note store. Output channel
// (out_valid/out_stall) carries at most one buzzer command per item; items
// that change nothing give no output.
// An accepted item lands in the input register; once the output register is
// free or being taken, its command is written into the output register, which
// drives out_valid. Throughput is one item per cycle while the output is not
// stalled: the note store is read ahead at the position the previous item
// leaves, so each item sees its note without waiting on the memory port.
// The melody registers are written through cfg_wr_en/cfg_index/cfg_data;
// the user must write only while no item is in flight; no check enforces it.
// Reset clears mode, elapsed time, error phase, position, the melody
// registers and both valid flags; the note store is not cleared and must be
// written before custom mode plays it. No clearing pass is needed.
// While out_stall holds a result, one more item is taken into the input
// register, then in_stall rises until the output is taken.
`default_nettype none
module buzzer_pattern_sequencer_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_wr_en,
	input  wire  [bps_pkg::CFG_IW-1:0]         cfg_index,
	input  wire  [bps_pkg::CFG_DW-1:0]         cfg_data,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire                                kind,
	input  wire  [bps_pkg::MODE_W-1:0]         mode,
	input  wire  [bps_pkg::SLOT_W-1:0]         note_slot,
	input  wire  [bps_pkg::FREQ_W-1:0]         note_frequency,
	input  wire  [bps_pkg::MS_W-1:0]           note_duration,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [1:0]                         command,
	output logic [bps_pkg::FREQ_W-1:0]         tone_frequency,
	output logic [bps_pkg::TLEN_W-1:0]         tone_length
);

	bps_pkg::cfg_t        cfg_q;
	bps_pkg::seq_state_t  state_q;
	bps_pkg::seq_state_t  state_nxt;
	bps_pkg::step_res_t   res;
	bps_pkg::note_t       rd_note;
	bps_pkg::note_t       first_note_q;
	bps_pkg::note_t       wr_note;

	logic                          valid_s1;
	logic                          kind_s1;
	logic [bps_pkg::MODE_W-1:0]    mode_s1;
	logic [bps_pkg::SLOT_W-1:0]    slot_s1;
	logic [bps_pkg::FREQ_W-1:0]    freq_s1;
	logic [bps_pkg::MS_W-1:0]      dur_s1;

	logic                          fire;
	logic                          take;
	logic                          note_wr;
	logic [bps_pkg::POS_W-1:0]     rd_pos;

	logic                          out_valid_q;
	bps_pkg::cmd_t                 command_q;
	logic [bps_pkg::FREQ_W-1:0]    freq_q;
	logic [bps_pkg::TLEN_W-1:0]    len_q;

	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign take     = in_valid && !in_stall;
	assign note_wr  = fire && kind_s1 &&
		({1'b0, slot_s1} < (bps_pkg::SLOT_W+1)'(bps_pkg::MAX_NOTES));
	assign wr_note  = '{pitch: freq_s1, wait_ms: dur_s1};
	assign rd_pos   = fire ? state_nxt.pos : state_q.pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bps_pkg::CFG_MELODY_PRESENT: cfg_q.present <= cfg_data[0];
				bps_pkg::CFG_MELODY_LENGTH:  cfg_q.length  <= cfg_data[bps_pkg::LEN_W-1:0];
				bps_pkg::CFG_MELODY_LOOP:    cfg_q.loop_en <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1 <= kind;
			mode_s1 <= mode;
			slot_s1 <= note_slot;
			freq_s1 <= note_frequency;
			dur_s1  <= note_duration;
		end
	end

	// keep slot 0 at hand for a mode change, which restarts the melody
	always_ff @(posedge clk) begin
		if (note_wr && (slot_s1 == '0)) begin
			first_note_q <= wr_note;
		end
	end

	bps_note_mem u_note_mem (
		.clk     (clk),
		.wr_en   (note_wr),
		.wr_addr (slot_s1[bps_pkg::NOTE_AW-1:0]),
		.wr_data (wr_note),
		.rd_addr (rd_pos[bps_pkg::NOTE_AW-1:0]),
		.rd_data (rd_note)
	);

	bps_step u_step (
		.kind       (kind_s1),
		.mode       (mode_s1),
		.cfg        (cfg_q),
		.cur        (state_q),
		.rd_note    (rd_note),
		.first_note (first_note_q),
		.nxt        (state_nxt),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			command_q <= res.command;
			freq_q    <= res.freq;
			len_q     <= res.len;
		end
	end

	assign out_valid      = out_valid_q;
	assign command        = command_q;
	assign tone_frequency = freq_q;
	assign tone_length    = len_q;

	a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	a_no_empty_command: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (command != bps_pkg::CMD_NONE))
		else $error("result carries no-change command");

	a_length_only_timed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (command != bps_pkg::CMD_TIMED)) |-> (tone_length == '0))
		else $error("tone length on untimed command");

	a_position_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pos <= bps_pkg::POS_W'(bps_pkg::MAX_NOTES))
		else $error("melody position past store");

	a_note_write_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && kind_s1) |=> ((state_q.pos == '0) && (state_q.elapsed == '0)))
		else $error("note write did not restart melody");

endmodule
`default_nettype wire
